>>> hdl/nbss_pkg.sv
// ----------------------------------------------------------------------------
// nbss_pkg
// Shared types and constants of the nearest bone segment search unit.
// ----------------------------------------------------------------------------
package nbss_pkg;

    // Default sizes of the segment table.
    localparam int MAX_BONES_DEF     = 256;
    localparam int JOINT_ID_BITS_DEF = 8;

    // Field widths.
    localparam int COORD_W  = 16;
    localparam int JOINT_W  = 8;
    localparam int WEIGHT_W = 17;
    localparam int DIST_W   = 32;
    localparam int T_BITS   = 16;
    localparam int MUL_W    = 18;
    localparam int ACC_W    = 38;

    localparam logic [COORD_W-1:0]  MAX_DIST_RESET = 16'd25600;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = 17'h10000;

    // Item kinds.
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_FOUND = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_TAKE,
        OP_WRITE,
        OP_CLEAR,
        OP_LIMIT,
        OP_READ,
        OP_LATCH,
        OP_MAC_C,
        OP_MAC_D,
        OP_CLAMP,
        OP_DIV,
        OP_PROJ,
        OP_DIST,
        OP_CMP,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       empty;
        logic       last;
        logic       clamp;
    } stat_t;

endpackage

>>> hdl/nbss_datapath.sv
// ----------------------------------------------------------------------------
// nbss_datapath
// Segment table, shared multiplier, accumulators, divider and result registers.
// ----------------------------------------------------------------------------
module nbss_datapath #(
    parameter int MAX_BONES     = nbss_pkg::MAX_BONES_DEF,
    parameter int JOINT_ID_BITS = nbss_pkg::JOINT_ID_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nbss_pkg::cmd_t                       cmd,
    output nbss_pkg::stat_t                      stat,
    input  logic [nbss_pkg::COORD_W-1:0]         max_distance,
    input  logic [1:0]                           kind,
    input  logic signed [nbss_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [nbss_pkg::COORD_W-1:0]  pos_y,
    input  logic signed [nbss_pkg::COORD_W-1:0]  pos_z,
    input  logic signed [nbss_pkg::COORD_W-1:0]  end_x,
    input  logic signed [nbss_pkg::COORD_W-1:0]  end_y,
    input  logic signed [nbss_pkg::COORD_W-1:0]  end_z,
    input  logic [nbss_pkg::JOINT_W-1:0]         start_joint,
    input  logic [nbss_pkg::JOINT_W-1:0]         end_joint,
    output logic [1:0]                           status,
    output logic [nbss_pkg::JOINT_W-1:0]         nearest_a,
    output logic [nbss_pkg::JOINT_W-1:0]         nearest_b,
    output logic [nbss_pkg::WEIGHT_W-1:0]        weight_a,
    output logic [nbss_pkg::DIST_W-1:0]          dist_sq
);

    localparam int CW    = $clog2(MAX_BONES + 1);
    localparam int AW    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int JB    = JOINT_ID_BITS;
    localparam int CRD   = nbss_pkg::COORD_W;
    localparam int MEM_W = 6 * CRD + 2 * JB;
    localparam int ACW   = nbss_pkg::ACC_W;
    localparam int MW    = nbss_pkg::MUL_W;
    localparam int TB    = nbss_pkg::T_BITS;

    // Latched input item.
    logic [1:0]                    kind_reg;
    logic signed [CRD-1:0]         p_reg [3];
    logic signed [CRD-1:0]         e_in_reg [3];
    logic [JB-1:0]                 sj_reg;
    logic [JB-1:0]                 ej_reg;

    // Table and its bookkeeping.
    logic [MEM_W-1:0]              mem [MAX_BONES];
    logic [MEM_W-1:0]              rd_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 k_reg;

    // Per-segment working registers.
    logic signed [CRD:0]           se_reg [3];
    logic signed [CRD:0]           sp_reg [3];
    logic signed [MW-1:0]          r_reg [3];
    logic [JB-1:0]                 cur_a_reg;
    logic [JB-1:0]                 cur_b_reg;
    logic signed [ACW-1:0]         acc_c_reg;
    logic signed [ACW-1:0]         acc_d_reg;
    logic signed [ACW-1:0]         acc_dist_reg;
    logic [ACW-1:0]                rem_reg;
    logic [TB-1:0]                 q_reg;

    // Best candidate so far.
    logic signed [ACW-1:0]         best_reg;
    logic                          found_reg;
    logic [JB-1:0]                 best_a_reg;
    logic [JB-1:0]                 best_b_reg;
    logic [nbss_pkg::WEIGHT_W-1:0] best_w_reg;
    logic [1:0]                    load_st_reg;

    logic signed [MW-1:0]          mul_a;
    logic signed [MW-1:0]          mul_b;
    logic signed [2*MW-1:0]        prod;
    logic signed [ACW-1:0]         prod_ext;
    logic signed [2*MW-1:0]        prod_rnd;
    logic signed [MW+2:0]          proj_r;
    logic                          c_le0;
    logic                          c_ge_d;
    logic [ACW-1:0]                rem_sh;
    logic [nbss_pkg::WEIGHT_W-1:0] weight;
    logic [JB+nbss_pkg::JOINT_W-1:0] ext_a;
    logic [JB+nbss_pkg::JOINT_W-1:0] ext_b;
    logic signed [CRD-1:0]         rd_s [3];
    logic signed [CRD-1:0]         rd_e [3];

    // Unpack the registered table word.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rd_s[i] = rd_reg[MEM_W-1-i*CRD -: CRD];
            rd_e[i] = rd_reg[MEM_W-1-(i+3)*CRD -: CRD];
        end
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        unique case (cmd.op)
            nbss_pkg::OP_LIMIT:
            begin
                mul_a = MW'({2'b00, max_distance});
                mul_b = MW'({2'b00, max_distance});
            end
            nbss_pkg::OP_MAC_C:
            begin
                mul_a = MW'(se_reg[cmd.axis]);
                mul_b = MW'(sp_reg[cmd.axis]);
            end
            nbss_pkg::OP_MAC_D:
            begin
                mul_a = MW'(se_reg[cmd.axis]);
                mul_b = MW'(se_reg[cmd.axis]);
            end
            nbss_pkg::OP_PROJ:
            begin
                mul_a = -MW'(se_reg[cmd.axis]);
                mul_b = MW'({2'b00, q_reg});
            end
            nbss_pkg::OP_DIST:
            begin
                mul_a = r_reg[cmd.axis];
                mul_b = r_reg[cmd.axis];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = ACW'(prod);

    // Projected offset rounds half up, then the residual p - proj.
    assign prod_rnd = prod + (2*MW)'(32768);
    assign proj_r   = -(MW+3)'(sp_reg[cmd.axis]) - (MW+3)'(prod_rnd >>> 16);

    assign c_le0  = (acc_c_reg <= 0);
    assign c_ge_d = (acc_c_reg >= acc_d_reg);
    assign rem_sh = {rem_reg[ACW-2:0], 1'b0};

    always_comb
    begin
        priority if (c_le0)
            weight = nbss_pkg::WEIGHT_ONE;
        else if (c_ge_d)
            weight = '0;
        else
            weight = nbss_pkg::WEIGHT_ONE - {1'b0, q_reg};
    end

    // Status to the controller.
    assign stat.kind  = kind_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.last  = (CW'(k_reg + 1'b1) == count_reg);
    assign stat.clamp = c_le0 || c_ge_d;

    // Table write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.op == nbss_pkg::OP_WRITE && count_reg != CW'(MAX_BONES))
        begin
            mem[count_reg[AW-1:0]] <= {p_reg[0], p_reg[1], p_reg[2],
                                       e_in_reg[0], e_in_reg[1], e_in_reg[2],
                                       sj_reg, ej_reg};
        end
        if (cmd.op == nbss_pkg::OP_READ)
        begin
            rd_reg <= mem[k_reg[AW-1:0]];
        end
    end

    // Control state of the datapath: fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.op == nbss_pkg::OP_CLEAR)
        begin
            count_reg <= '0;
        end
        else if (cmd.op == nbss_pkg::OP_WRITE && count_reg != CW'(MAX_BONES))
        begin
            count_reg <= CW'(count_reg + 1'b1);
        end
    end

    // Arithmetic and payload registers.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            nbss_pkg::OP_TAKE:
            begin
                kind_reg    <= kind;
                p_reg[0]    <= pos_x;
                p_reg[1]    <= pos_y;
                p_reg[2]    <= pos_z;
                e_in_reg[0] <= end_x;
                e_in_reg[1] <= end_y;
                e_in_reg[2] <= end_z;
                sj_reg      <= JB'(start_joint);
                ej_reg      <= JB'(end_joint);
            end
            nbss_pkg::OP_WRITE:
            begin
                load_st_reg <= (count_reg != CW'(MAX_BONES)) ? nbss_pkg::ST_DONE
                                                             : nbss_pkg::ST_FULL;
            end
            nbss_pkg::OP_LIMIT:
            begin
                best_reg  <= prod_ext;
                found_reg <= 1'b0;
                k_reg     <= '0;
            end
            nbss_pkg::OP_LATCH:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    se_reg[i] <= (CRD+1)'(rd_s[i]) - (CRD+1)'(rd_e[i]);
                    sp_reg[i] <= (CRD+1)'(rd_s[i]) - (CRD+1)'(p_reg[i]);
                end
                cur_a_reg <= rd_reg[2*JB-1:JB];
                cur_b_reg <= rd_reg[JB-1:0];
            end
            nbss_pkg::OP_MAC_C:
            begin
                acc_c_reg <= (cmd.axis == 2'd0) ? prod_ext : acc_c_reg + prod_ext;
            end
            nbss_pkg::OP_MAC_D:
            begin
                acc_d_reg <= (cmd.axis == 2'd0) ? prod_ext : acc_d_reg + prod_ext;
            end
            nbss_pkg::OP_CLAMP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (c_le0)
                        r_reg[i] <= MW'(sp_reg[i]);
                    else
                        r_reg[i] <= MW'(sp_reg[i]) - MW'(se_reg[i]);
                end
                rem_reg <= acc_c_reg;
                q_reg   <= '0;
            end
            nbss_pkg::OP_DIV:
            begin
                // One quotient bit per cycle, restoring division.
                if (rem_sh >= ACW'(acc_d_reg))
                begin
                    rem_reg <= rem_sh - ACW'(acc_d_reg);
                    q_reg   <= {q_reg[TB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[TB-2:0], 1'b0};
                end
            end
            nbss_pkg::OP_PROJ:
            begin
                r_reg[cmd.axis] <= proj_r[MW-1:0];
            end
            nbss_pkg::OP_DIST:
            begin
                acc_dist_reg <= (cmd.axis == 2'd0) ? prod_ext : acc_dist_reg + prod_ext;
            end
            nbss_pkg::OP_CMP:
            begin
                if (acc_dist_reg < best_reg)
                begin
                    best_reg   <= acc_dist_reg;
                    found_reg  <= 1'b1;
                    best_a_reg <= cur_a_reg;
                    best_b_reg <= cur_b_reg;
                    best_w_reg <= weight;
                end
                k_reg <= CW'(k_reg + 1'b1);
            end
            nbss_pkg::OP_OUT:
            begin
                // A found bone carries its payload; every other result has a zero payload.
                if (kind_reg == nbss_pkg::KIND_QUERY && found_reg)
                begin
                    status    <= nbss_pkg::ST_FOUND;
                    nearest_a <= ext_a[nbss_pkg::JOINT_W-1:0];
                    nearest_b <= ext_b[nbss_pkg::JOINT_W-1:0];
                    weight_a  <= best_w_reg;
                    dist_sq   <= best_reg[nbss_pkg::DIST_W-1:0];
                end
                else
                begin
                    if (kind_reg == nbss_pkg::KIND_LOAD)
                        status <= load_st_reg;
                    else if (kind_reg == nbss_pkg::KIND_QUERY)
                        status <= nbss_pkg::ST_NONE;
                    else
                        status <= nbss_pkg::ST_DONE;
                    nearest_a <= '0;
                    nearest_b <= '0;
                    weight_a  <= '0;
                    dist_sq   <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign ext_a = {{nbss_pkg::JOINT_W{1'b0}}, best_a_reg};
    assign ext_b = {{nbss_pkg::JOINT_W{1'b0}}, best_b_reg};

endmodule

>>> hdl/nbss_controller.sv
// ----------------------------------------------------------------------------
// nbss_controller
// Sequencer that walks the segment table for a query and runs the handshakes.
// ----------------------------------------------------------------------------
module nbss_controller (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  nbss_pkg::stat_t stat,
    output nbss_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_LATCH,
        S_MAC_C,
        S_MAC_D,
        S_CLAMP,
        S_DIV,
        S_PROJ,
        S_DIST,
        S_CMP,
        S_OUT
    } state_t;

    localparam logic [3:0] DIV_LAST = 4'(nbss_pkg::T_BITS - 1);

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] ax_reg;
    logic [1:0] ax_next;
    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command.
    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        cnt_next       = cnt_reg;
        cmd.op         = nbss_pkg::OP_NONE;
        cmd.axis       = ax_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = nbss_pkg::OP_TAKE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_OUT;
                unique case (stat.kind)
                    nbss_pkg::KIND_LOAD:  cmd.op = nbss_pkg::OP_WRITE;
                    nbss_pkg::KIND_CLEAR: cmd.op = nbss_pkg::OP_CLEAR;
                    nbss_pkg::KIND_QUERY:
                    begin
                        cmd.op = nbss_pkg::OP_LIMIT;
                        if (!stat.empty)
                            state_next = S_READ;
                    end
                    default: cmd.op = nbss_pkg::OP_NONE;
                endcase
            end
            S_READ:
            begin
                cmd.op     = nbss_pkg::OP_READ;
                state_next = S_LATCH;
            end
            S_LATCH:
            begin
                cmd.op     = nbss_pkg::OP_LATCH;
                ax_next    = 2'd0;
                state_next = S_MAC_C;
            end
            S_MAC_C:
            begin
                cmd.op  = nbss_pkg::OP_MAC_C;
                ax_next = (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                if (ax_reg == 2'd2)
                    state_next = S_MAC_D;
            end
            S_MAC_D:
            begin
                cmd.op  = nbss_pkg::OP_MAC_D;
                ax_next = (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                if (ax_reg == 2'd2)
                    state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.op     = nbss_pkg::OP_CLAMP;
                cnt_next   = '0;
                ax_next    = 2'd0;
                state_next = stat.clamp ? S_DIST : S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = nbss_pkg::OP_DIV;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_PROJ;
            end
            S_PROJ:
            begin
                cmd.op  = nbss_pkg::OP_PROJ;
                ax_next = (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                if (ax_reg == 2'd2)
                    state_next = S_DIST;
            end
            S_DIST:
            begin
                cmd.op  = nbss_pkg::OP_DIST;
                ax_next = (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                if (ax_reg == 2'd2)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.op     = nbss_pkg::OP_CMP;
                state_next = stat.last ? S_OUT : S_READ;
            end
            S_OUT:
            begin
                // Wait until the output register is free, then load it.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = nbss_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ax_reg        <= 2'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ax_reg        <= ax_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/nearest_bone_segment_search_unit.sv
// ----------------------------------------------------------------------------
// nearest_bone_segment_search_unit
// Nearest bone segment search over a table of loaded segments.
// ----------------------------------------------------------------------------
// A load, a clear and kind 3, which does nothing, each pass from the input
// transfer straight to the result. A query also walks every stored segment,
// skipping the divider and projection steps when the projection clamps to an
// end, and a full table holds 256 segments by default.
// The search time is set by the single shared multiplier, used once per axis for
// each dot product and squared length, and by the quotient divider.
// The next item is taken while a finished result still waits to be taken.
module nearest_bone_segment_search_unit #(
    parameter int MAX_BONES     = nbss_pkg::MAX_BONES_DEF,
    parameter int JOINT_ID_BITS = nbss_pkg::JOINT_ID_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           kind,
    input  logic signed [nbss_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [nbss_pkg::COORD_W-1:0]  pos_y,
    input  logic signed [nbss_pkg::COORD_W-1:0]  pos_z,
    input  logic signed [nbss_pkg::COORD_W-1:0]  end_x,
    input  logic signed [nbss_pkg::COORD_W-1:0]  end_y,
    input  logic signed [nbss_pkg::COORD_W-1:0]  end_z,
    input  logic [nbss_pkg::JOINT_W-1:0]         start_joint,
    input  logic [nbss_pkg::JOINT_W-1:0]         end_joint,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           status,
    output logic [nbss_pkg::JOINT_W-1:0]         nearest_a,
    output logic [nbss_pkg::JOINT_W-1:0]         nearest_b,
    output logic [nbss_pkg::WEIGHT_W-1:0]        weight_a,
    output logic [nbss_pkg::DIST_W-1:0]          dist_sq
);

    logic [nbss_pkg::COORD_W-1:0] max_dist_reg;
    logic                         cfg_hit;
    nbss_pkg::cmd_t               cmd;
    nbss_pkg::stat_t              stat;

    // Configuration register: the search limit, at every address with paddr[2] low.
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == 1'b0);
    assign prdata  = cfg_hit ? {16'd0, max_dist_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= nbss_pkg::MAX_DIST_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            max_dist_reg <= pwdata[nbss_pkg::COORD_W-1:0];
        end
    end

    nbss_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    nbss_datapath #(
        .MAX_BONES     (MAX_BONES),
        .JOINT_ID_BITS (JOINT_ID_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .max_distance (max_dist_reg),
        .kind         (kind),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .end_x        (end_x),
        .end_y        (end_y),
        .end_z        (end_z),
        .start_joint  (start_joint),
        .end_joint    (end_joint),
        .status       (status),
        .nearest_a    (nearest_a),
        .nearest_b    (nearest_b),
        .weight_a     (weight_a),
        .dist_sq      (dist_sq)
    );

endmodule

>>> hdl/nbss_checker.sv
// ----------------------------------------------------------------------------
// nbss_checker
// Port-level checks of the nearest bone segment search unit.
// ----------------------------------------------------------------------------
module nbss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [7:0]  nearest_a,
    input logic [7:0]  nearest_b,
    input logic [16:0] weight_a,
    input logic [31:0] dist_sq
);

    // A held result keeps its status.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result changed while stalled");

    // After a transfer in, the unit is busy in the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

    // A result without a found bone carries zero payload.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != nbss_pkg::ST_FOUND |->
            nearest_a == 8'd0 && nearest_b == 8'd0 &&
            weight_a == 17'd0 && dist_sq == 32'd0)
        else $error("payload set without a found bone");

    // The start weight never exceeds one.
    a_weight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> weight_a <= nbss_pkg::WEIGHT_ONE)
        else $error("weight out of range");

endmodule

bind nearest_bone_segment_search_unit nbss_checker u_nbss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .nearest_a (nearest_a),
    .nearest_b (nearest_b),
    .weight_a  (weight_a),
    .dist_sq   (dist_sq)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the nearest bone segment search unit. Segment
// loads, table clears and point queries are sent over the input channel with
// random gaps. Each transfer is run through a behavioral predictor of the
// segment table, and every result transfer is compared field by field with
// the oldest predicted result. The search limit register is written over the
// APB port between phases, while the unit is idle.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] KIND_NOP  = 2'd3;
    localparam logic [2:0] ADDR_MAX_DIST = 3'd0;
    localparam int         CYCLE_LIMIT = 4000000;
    localparam int         TABLE_SIZE = nbss_pkg::MAX_BONES_DEF;

    typedef struct {
        logic [1:0]                    st;
        logic [nbss_pkg::JOINT_W-1:0]  a;
        logic [nbss_pkg::JOINT_W-1:0]  b;
        logic [nbss_pkg::WEIGHT_W-1:0] w;
        logic [nbss_pkg::DIST_W-1:0]   d;
    } bone_result_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [1:0] kind, status;
    logic signed [nbss_pkg::COORD_W-1:0] pos_x, pos_y, pos_z, end_x, end_y, end_z;
    logic [nbss_pkg::JOINT_W-1:0] start_joint, end_joint, nearest_a, nearest_b;
    logic [nbss_pkg::WEIGHT_W-1:0] weight_a;
    logic [nbss_pkg::DIST_W-1:0] dist_sq;

    // Predictor state: a copy of the segment table and the search limit.
    int          seg_start [TABLE_SIZE][3];
    int          seg_end   [TABLE_SIZE][3];
    logic [7:0]  seg_ja    [TABLE_SIZE];
    logic [7:0]  seg_jb    [TABLE_SIZE];
    int          seg_count;
    longint      limit_q88;

    bone_result_t pending_results[$];
    int  errors;
    int  cycles;
    bit  calm;

    nearest_bone_segment_search_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .end_x(end_x), .end_y(end_y), .end_z(end_z),
        .start_joint(start_joint), .end_joint(end_joint),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .nearest_a(nearest_a), .nearest_b(nearest_b),
        .weight_a(weight_a), .dist_sq(dist_sq)
    );

    // Clock generation.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Round to nearest, halves toward plus infinity, in Q16 units.
    function automatic longint round_q16(longint x);
        longint y;
        y = x + 32768;
        if (y >= 0)
            return y / 65536;
        return -((-y + 65535) / 65536);
    endfunction

    // Squared distance from point p to segment k, with the start joint weight.
    function automatic longint segment_distance(int p[3], int k, output longint wgt);
        longint se[3], sp[3], r[3];
        longint c, d, t, proj;
        c = 0;
        for (int i = 0; i < 3; i++)
        begin
            se[i] = longint'(seg_start[k][i]) - seg_end[k][i];
            sp[i] = longint'(seg_start[k][i]) - p[i];
            c += se[i] * sp[i];
        end
        if (c <= 0)
        begin
            wgt = 65536;
            return sp[0] * sp[0] + sp[1] * sp[1] + sp[2] * sp[2];
        end
        d = se[0] * se[0] + se[1] * se[1] + se[2] * se[2];
        if (c >= d || d <= 0)
        begin
            for (int i = 0; i < 3; i++)
                r[i] = longint'(seg_end[k][i]) - p[i];
            wgt = 0;
            return r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
        end
        t = (c * 65536) / d;
        wgt = 65536 - t;
        for (int i = 0; i < 3; i++)
        begin
            proj = longint'(seg_start[k][i]) + round_q16(-se[i] * t);
            r[i] = longint'(p[i]) - proj;
        end
        return r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
    endfunction

    // Apply one accepted item to the table copy and queue its result.
    function automatic void predict_search(logic [1:0] k, int s[3], int e[3],
                                           logic [7:0] ja, logic [7:0] jb);
        bone_result_t res;
        longint best, dd, w;
        bit found;
        res = '{st: nbss_pkg::ST_DONE, a: '0, b: '0, w: '0, d: '0};
        if (k == nbss_pkg::KIND_LOAD)
        begin
            if (seg_count < TABLE_SIZE)
            begin
                seg_start[seg_count] = s;
                seg_end[seg_count] = e;
                seg_ja[seg_count] = ja;
                seg_jb[seg_count] = jb;
                seg_count++;
            end
            else
                res.st = nbss_pkg::ST_FULL;
        end
        else if (k == nbss_pkg::KIND_QUERY)
        begin
            best = limit_q88 * limit_q88;
            found = 0;
            for (int i = 0; i < seg_count; i++)
            begin
                dd = segment_distance(s, i, w);
                if (dd < best)
                begin
                    best = dd;
                    found = 1;
                    res.a = seg_ja[i];
                    res.b = seg_jb[i];
                    res.w = w[nbss_pkg::WEIGHT_W-1:0];
                end
            end
            if (found)
            begin
                res.st = nbss_pkg::ST_FOUND;
                res.d = best[nbss_pkg::DIST_W-1:0];
            end
            else
                res.st = nbss_pkg::ST_NONE;
        end
        else if (k == nbss_pkg::KIND_CLEAR)
            seg_count = 0;
        pending_results.insert(pending_results.size(), res);
    endfunction

    // Send one item; valid stays high afterwards unless the next call idles.
    task automatic send_item(logic [1:0] k, int s[3], int e[3],
                             logic [7:0] ja = 8'd0, logic [7:0] jb = 8'd0);
        if (!calm && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 50);
        end
        in_valid <= 1'b1;
        kind <= k;
        pos_x <= s[0]; pos_y <= s[1]; pos_z <= s[2];
        end_x <= e[0]; end_y <= e[1]; end_z <= e[2];
        start_joint <= ja;
        end_joint <= jb;
        do
            @(posedge clk);
        while (!in_ready);
        predict_search(k, s, e, ja, jb);
    endtask

    task automatic send_query(int x, int y, int z);
        int p[3] = '{x, y, z};
        int z3[3] = '{0, 0, 0};
        send_item(nbss_pkg::KIND_QUERY, p, z3);
    endtask

    task automatic send_clear();
        int z3[3] = '{0, 0, 0};
        send_item(nbss_pkg::KIND_CLEAR, z3, z3);
    endtask

    // Stop sending and wait until every predicted result has arrived.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // APB write of the search limit, only while the unit is idle.
    task automatic write_limit(logic [15:0] value);
        wait_drained();
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_MAX_DIST; pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        limit_q88 = value;
    endtask

    function automatic int rand_coord();
        return int'($signed(16'($urandom)));
    endfunction

    // Empty table and the unused kind right after reset.
    task automatic test_empty_table();
        send_query(0, 0, 0);
        send_item(KIND_NOP, '{-1, -1, -1}, '{-1, -1, -1}, 8'hFF, 8'hFF);
        send_query(-32768, 32767, -32768);
    endtask

    // Field extremes, clamping at both ends, interior projection, a
    // zero-length segment and a tie between identical segments.
    task automatic test_directed_geometry();
        send_clear();
        send_item(nbss_pkg::KIND_LOAD, '{-32768, -32768, -32768},
                  '{32767, 32767, 32767}, 8'hFF, 8'h00);
        send_item(nbss_pkg::KIND_LOAD, '{100, 200, 300}, '{100, 200, 300},
                  8'h00, 8'hFF);
        send_item(nbss_pkg::KIND_LOAD, '{0, 0, 0}, '{2560, 0, 0}, 8'h55, 8'hAA);
        send_item(nbss_pkg::KIND_LOAD, '{0, 0, 0}, '{2560, 0, 0}, 8'hAA, 8'h55);
        send_query(-32768, -32768, -32768);
        send_query(32767, 32767, 32767);
        send_query(-1000, 10, 0);
        send_query(4000, -10, 5);
        send_query(1281, 300, -77);
        send_query(100, 200, 300);
        send_query(32767, -32768, 0);
        send_query(777, 333, 129);
    endtask

    // Search limit at zero, at its maximum, at one and back at the reset value.
    task automatic test_limit_extremes();
        write_limit(16'd0);
        send_query(1281, 0, 0);
        send_query(100, 200, 300);
        write_limit(16'hFFFF);
        send_query(32767, -32768, 32767);
        send_query(-20000, 20000, 123);
        write_limit(16'd1);
        send_query(100, 200, 300);
        send_query(101, 200, 300);
        write_limit(nbss_pkg::MAX_DIST_RESET);
        send_query(1281, 2000, 0);
    endtask

    // Fill the table, overflow it by one load, and search the full table.
    task automatic test_full_table();
        int s[3], e[3];
        send_clear();
        for (int i = 0; i < TABLE_SIZE + 1; i++)
        begin
            s = '{rand_coord() / 8, rand_coord() / 8, rand_coord() / 8};
            e = '{s[0] + $urandom_range(2000), s[1] - $urandom_range(2000),
                  s[2] + $urandom_range(2000)};
            send_item(nbss_pkg::KIND_LOAD, s, e, 8'($urandom), 8'($urandom));
        end
        send_query(0, 0, 0);
        send_query(rand_coord() / 8, rand_coord() / 8, rand_coord() / 8);
        send_clear();
    endtask

    // Random phases: mostly a cleared table with a few segments around a
    // center and queries near them, plus raw noise items.
    task automatic test_random_search();
        int cx, cy, cz, n, pick, sent;
        int s[3], e[3];
        sent = 0;
        while (sent < 700)
        begin
            if (sent % 150 == 0 && sent != 0)
                write_limit(($urandom_range(3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(500, 8000)));
            calm = ((sent / 100) % 4 == 2);
            if ($urandom_range(9) == 0)
            begin
                // Noise: any kind with full-range fields while the table holds under 16 segments, else a query.
                s = '{rand_coord(), rand_coord(), rand_coord()};
                e = '{rand_coord(), rand_coord(), rand_coord()};
                if (seg_count < 16)
                    send_item(2'($urandom), s, e, 8'($urandom), 8'($urandom));
                else
                    send_item(nbss_pkg::KIND_QUERY, s, e);
                sent++;
                continue;
            end
            cx = $urandom_range(32000) - 16000;
            cy = $urandom_range(32000) - 16000;
            cz = $urandom_range(32000) - 16000;
            n = $urandom_range(1, 12);
            send_clear();
            sent++;
            for (int i = 0; i < n; i++)
            begin
                s = '{cx + $urandom_range(8000) - 4000, cy + $urandom_range(8000) - 4000,
                      cz + $urandom_range(8000) - 4000};
                pick = $urandom_range(9);
                if (pick == 0)
                    e = s;
                else
                    e = '{s[0] + $urandom_range(8000) - 4000,
                          s[1] + $urandom_range(8000) - 4000,
                          s[2] + $urandom_range(8000) - 4000};
                send_item(nbss_pkg::KIND_LOAD, s, e, 8'($urandom), 8'($urandom));
                sent++;
            end
            for (int i = 0; i < n + 2; i++)
            begin
                pick = $urandom_range(n - 1);
                send_query(seg_start[pick][0] + $urandom_range(6000) - 3000,
                           seg_start[pick][1] + $urandom_range(6000) - 3000,
                           seg_end[pick][2] + $urandom_range(6000) - 3000);
                sent++;
            end
            if ($urandom_range(19) == 0)
                wait_drained();
        end
        calm = 0;
    endtask

    // Receiver stalls.
    always @(posedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 33);

    // Compare every result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        bone_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no prediction: status %0d", $time, status);
                errors++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (status !== exp_res.st || nearest_a !== exp_res.a ||
                    nearest_b !== exp_res.b || weight_a !== exp_res.w ||
                    dist_sq !== exp_res.d)
                begin
                    $display("%0t: mismatch expected st=%0d a=%0d b=%0d w=%0d d=%0d",
                             $time, exp_res.st, exp_res.a, exp_res.b, exp_res.w,
                             exp_res.d);
                    $display("%0t:          actual   st=%0d a=%0d b=%0d w=%0d d=%0d",
                             $time, status, nearest_a, nearest_b, weight_a, dist_sq);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        calm = 0;
        seg_count = 0;
        limit_q88 = nbss_pkg::MAX_DIST_RESET;
        rst_n <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        paddr <= '0; pwdata <= '0;
        in_valid <= 1'b0; kind <= nbss_pkg::KIND_LOAD;
        pos_x <= '0; pos_y <= '0; pos_z <= '0;
        end_x <= '0; end_y <= '0; end_z <= '0;
        start_joint <= '0; end_joint <= '0;
        out_ready <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_directed_geometry();
        test_limit_extremes();
        test_full_table();
        test_random_search();

        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
